>>> src/vfcm_pkg.sv
// Shared types and codes for the voxel face-culling mesher.
// No dependencies; used by voxel_face_cull_mesher.
package vfcm_pkg;

    localparam int COORD_W = 4;
    localparam int COL_W   = 8;
    localparam int SIDE_W  = 3;
    localparam int VC_W    = 20;
    localparam int MODE_W  = 2;

    // request modes
    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MESH  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RESTART = 2'd2;

    // face sides, in emission order
    localparam logic [SIDE_W-1:0] SIDE_PX = 3'd0;
    localparam logic [SIDE_W-1:0] SIDE_NX = 3'd1;
    localparam logic [SIDE_W-1:0] SIDE_PY = 3'd2;
    localparam logic [SIDE_W-1:0] SIDE_NY = 3'd3;
    localparam logic [SIDE_W-1:0] SIDE_PZ = 3'd4;
    localparam logic [SIDE_W-1:0] SIDE_NZ = 3'd5;

    // one voxel store word
    typedef struct packed {
        logic             active;
        logic [COL_W-1:0] red;
        logic [COL_W-1:0] green;
        logic [COL_W-1:0] blue;
    } t_cell;

endpackage

>>> src/voxel_face_cull_mesher.sv
// Voxel store with culled-face mesher: top level, store memory and sequencer.
// Depends on vfcm_pkg.
//
// A request is taken when start is high and busy is low. A write (mode 0) or a
// counter restart (mode 2) completes at the accepting edge and leaves busy low.
// A mesh request (mode 1) reads the addressed cell and then its six neighbours
// through the single read port of the voxel store, one read a cycle. Busy stays
// high through the centre read and the six neighbour reads, and through the flush
// state as well when the -z side is open along with any other side. It drops after
// the centre read when the cell is inactive. Faces appear on the o_face_* ports
// one cycle each, marked by o_face_valid, overlapped with the neighbour reads.
// They cannot be held off, so the receiver must take them as they come. After
// reset the store is swept to zero, one cell a cycle, with busy high until all
// 2^(XW+YW+ZW) cells (4096 at the default 16x16x16) are cleared.
module voxel_face_cull_mesher #(
    parameter int SIZE_X = 16,
    parameter int SIZE_Y = 16,
    parameter int SIZE_Z = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [vfcm_pkg::MODE_W-1:0]    i_mode,
    input  logic [vfcm_pkg::COORD_W-1:0]   i_cell_x,
    input  logic [vfcm_pkg::COORD_W-1:0]   i_cell_y,
    input  logic [vfcm_pkg::COORD_W-1:0]   i_cell_z,
    input  logic                           i_set_active,
    input  logic [vfcm_pkg::COL_W-1:0]     i_set_red,
    input  logic [vfcm_pkg::COL_W-1:0]     i_set_green,
    input  logic [vfcm_pkg::COL_W-1:0]     i_set_blue,
    output logic                           o_face_valid,
    output logic [vfcm_pkg::SIDE_W-1:0]    o_face_side,
    output logic [vfcm_pkg::COORD_W-1:0]   o_corner_x,
    output logic [vfcm_pkg::COORD_W-1:0]   o_corner_y,
    output logic [vfcm_pkg::COORD_W-1:0]   o_corner_z,
    output logic [vfcm_pkg::COL_W-1:0]     o_face_red,
    output logic [vfcm_pkg::COL_W-1:0]     o_face_green,
    output logic [vfcm_pkg::COL_W-1:0]     o_face_blue,
    output logic [vfcm_pkg::VC_W-1:0]      o_base_vertex,
    output logic                           o_last_face
);

    // reachable extent per axis: coordinates are only 4 bits wide
    localparam int LIM_X = (SIZE_X > 16) ? 16 : SIZE_X;
    localparam int LIM_Y = (SIZE_Y > 16) ? 16 : SIZE_Y;
    localparam int LIM_Z = (SIZE_Z > 16) ? 16 : SIZE_Z;
    localparam int XW    = $clog2(LIM_X);
    localparam int YW    = $clog2(LIM_Y);
    localparam int ZW    = $clog2(LIM_Z);
    localparam int AW    = XW + YW + ZW;
    localparam int DEPTH = 1 << AW;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CLEAR = 2'd1;
    localparam logic [1:0] ST_MESH  = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    localparam logic [2:0] STEP_LAST = 3'd6;

    // voxel store
    vfcm_pkg::t_cell r_mem [DEPTH];
    vfcm_pkg::t_cell r_rd_data;

    logic [1:0]                          r_state, n_state;
    logic [AW-1:0]                       r_clr_addr;
    logic [2:0]                          r_step, n_step;
    logic [vfcm_pkg::COORD_W-1:0]        r_x, r_y, r_z;
    logic [vfcm_pkg::COL_W-1:0]          r_red, r_green, r_blue;
    logic                                r_pend_vld, n_pend_vld;
    logic [vfcm_pkg::SIDE_W-1:0]         r_pend_side, n_pend_side;
    logic [vfcm_pkg::VC_W-1:0]           r_vcount, n_vcount;
    logic                                r_out_vld, n_out_vld;
    logic [vfcm_pkg::SIDE_W-1:0]         r_out_side, n_out_side;
    logic                                r_out_last, n_out_last;
    logic [vfcm_pkg::VC_W-1:0]           r_out_base, n_out_base;

    logic                                acc;
    logic                                in_range;
    logic [AW-1:0]                       in_addr;
    logic [AW-1:0]                       rd_addr;
    logic                                wr_en;
    logic [AW-1:0]                       wr_addr;
    vfcm_pkg::t_cell                     wr_data;
    logic [AW:0]                         nb_issue;
    logic [AW:0]                         nb_check;
    logic [vfcm_pkg::SIDE_W-1:0]         chk_side;
    logic                                side_open;
    logic                                emit;
    logic [vfcm_pkg::SIDE_W-1:0]         emit_side;
    logic                                emit_last;

    // neighbour of a cell on one side: {outside, address}
    function automatic logic [AW:0] nb_of(input logic [vfcm_pkg::SIDE_W-1:0] side,
                                          input logic [vfcm_pkg::COORD_W-1:0] x,
                                          input logic [vfcm_pkg::COORD_W-1:0] y,
                                          input logic [vfcm_pkg::COORD_W-1:0] z);
        logic [vfcm_pkg::COORD_W:0] nx, ny, nz;
        logic                       outside;
        nx = {1'b0, x};
        ny = {1'b0, y};
        nz = {1'b0, z};
        outside = 1'b0;
        case (side)
            vfcm_pkg::SIDE_PX: begin
                nx = nx + 5'd1;
                outside = int'(nx) >= LIM_X;
            end
            vfcm_pkg::SIDE_NX: begin
                outside = (x == '0);
                nx = nx - 5'd1;
            end
            vfcm_pkg::SIDE_PY: begin
                ny = ny + 5'd1;
                outside = int'(ny) >= LIM_Y;
            end
            vfcm_pkg::SIDE_NY: begin
                outside = (y == '0);
                ny = ny - 5'd1;
            end
            vfcm_pkg::SIDE_PZ: begin
                nz = nz + 5'd1;
                outside = int'(nz) >= LIM_Z;
            end
            vfcm_pkg::SIDE_NZ: begin
                outside = (z == '0);
                nz = nz - 5'd1;
            end
            default: begin
                outside = 1'b1;
            end
        endcase
        return {outside, nx[XW-1:0], ny[YW-1:0], nz[ZW-1:0]};
    endfunction

    assign busy   = (r_state != ST_IDLE);
    assign acc    = start && !busy;
    assign in_range = (int'(i_cell_x) < SIZE_X) && (int'(i_cell_y) < SIZE_Y)
                   && (int'(i_cell_z) < SIZE_Z);
    assign in_addr = {i_cell_x[XW-1:0], i_cell_y[YW-1:0], i_cell_z[ZW-1:0]};

    // read for the next step is issued while the current step's data is checked
    assign nb_issue = nb_of(r_step, r_x, r_y, r_z);
    assign chk_side = r_step - 3'd1;
    assign nb_check = nb_of(chk_side, r_x, r_y, r_z);
    assign side_open = nb_check[AW] || !r_rd_data.active;
    assign rd_addr  = (r_state == ST_MESH) ? nb_issue[AW-1:0] : in_addr;

    // store write: clearing sweep or a write request
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = in_addr;
        wr_data = '{active: i_set_active, red: i_set_red,
                    green: i_set_green, blue: i_set_blue};
        if (r_state == ST_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = '0;
        end else if (acc && (i_mode == vfcm_pkg::MODE_WRITE) && in_range) begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // sequencer: centre read, six neighbour reads, faces held back one so last is known
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_pend_vld  = r_pend_vld;
        n_pend_side = r_pend_side;
        emit        = 1'b0;
        emit_side   = r_pend_side;
        emit_last   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (acc && (i_mode == vfcm_pkg::MODE_MESH) && in_range) begin
                    n_state    = ST_MESH;
                    n_step     = '0;
                    n_pend_vld = 1'b0;
                end
            end
            ST_CLEAR: begin
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_MESH: begin
                n_step = r_step + 3'd1;
                if (r_step == '0) begin
                    if (!r_rd_data.active) begin
                        n_state = ST_IDLE;
                    end
                end else if (r_step != STEP_LAST) begin
                    if (side_open) begin
                        emit        = r_pend_vld;
                        n_pend_vld  = 1'b1;
                        n_pend_side = chk_side;
                    end
                end else begin
                    n_state = ST_IDLE;
                    if (side_open && r_pend_vld) begin
                        emit        = 1'b1;
                        n_pend_side = chk_side;
                        n_state     = ST_FLUSH;
                    end else if (side_open) begin
                        emit      = 1'b1;
                        emit_side = chk_side;
                        emit_last = 1'b1;
                    end else if (r_pend_vld) begin
                        emit      = 1'b1;
                        emit_last = 1'b1;
                    end
                end
            end
            ST_FLUSH: begin
                emit      = 1'b1;
                emit_last = 1'b1;
                n_state   = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // face output and vertex counter
    always_comb begin
        n_vcount   = r_vcount;
        n_out_vld  = emit;
        n_out_side = emit_side;
        n_out_last = emit_last;
        n_out_base = r_vcount;
        if (emit) begin
            n_vcount = r_vcount + 20'd4;
        end else if (acc && (i_mode == vfcm_pkg::MODE_RESTART)) begin
            n_vcount = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_step     <= '0;
            r_pend_vld <= 1'b0;
            r_vcount   <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_step     <= n_step;
            r_pend_vld <= n_pend_vld;
            r_vcount   <= n_vcount;
            r_out_vld  <= n_out_vld;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pend_side <= n_pend_side;
        r_out_side  <= n_out_side;
        r_out_last  <= n_out_last;
        r_out_base  <= n_out_base;
        if (acc) begin
            r_x <= i_cell_x;
            r_y <= i_cell_y;
            r_z <= i_cell_z;
        end
        if ((r_state == ST_MESH) && (r_step == '0)) begin
            r_red   <= r_rd_data.red;
            r_green <= r_rd_data.green;
            r_blue  <= r_rd_data.blue;
        end
    end

    assign o_face_valid  = r_out_vld;
    assign o_face_side   = r_out_side;
    assign o_corner_x    = r_x;
    assign o_corner_y    = r_y;
    assign o_corner_z    = r_z;
    assign o_face_red    = r_red;
    assign o_face_green  = r_green;
    assign o_face_blue   = r_blue;
    assign o_base_vertex = r_out_base;
    assign o_last_face   = r_out_last;

    // a face only follows a meshing step
    a_face_from_mesh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> ($past(r_state) == ST_MESH || $past(r_state) == ST_FLUSH))
        else $error("face emitted outside a mesh request");

    // a face that is not the last keeps the block busy for the rest
    a_more_faces_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out_last) |-> busy)
        else $error("non-final face with block idle");

    // counter has moved on by one face once a face is shown
    a_counter_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_vcount == (r_out_base + 20'd4)))
        else $error("vertex counter out of step with face");

    // flush only with a held face
    a_flush_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FLUSH) |-> r_pend_vld)
        else $error("flush without a pending face");

    // the store is never written while a mesh request reads it
    a_no_write_in_mesh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_state != ST_MESH && r_state != ST_FLUSH))
        else $error("store written during meshing");

endmodule
